### sv/ytr_pkg.sv
// Shared types, coefficients and the output clamp for the YCbCr to RGB pixel-group core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ytr_pkg;

   localparam int WIDE_W     = 28;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [7:0]              byte_type;
   typedef logic signed [8:0]       term_type;
   typedef logic signed [18:0]      coef_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic [CSR_ADDR_W-1:0]   csr_addr_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;

   typedef enum logic {
      MODE_PLANAR_STUDIO = 1'b0,
      MODE_PACKED_FULL   = 1'b1
   } mode_type;

   localparam logic REG_CHROMA_MODE = 1'b0;

   // planar 4:2:0, studio range, 16.16
   localparam coef_type K0_Y  = 19'sd76283;
   localparam coef_type K0_RV = 19'sd104595;
   localparam coef_type K0_GV = -19'sd53280;
   localparam coef_type K0_GU = -19'sd25690;
   localparam coef_type K0_BU = 19'sd132186;
   localparam term_type LUMA_OFS0 = 9'sd16;

   // packed 4:2:2, full range, 8.8 scaled up to 16.16
   localparam coef_type K1_Y  = 19'sd65536;
   localparam coef_type K1_RV = 19'sd91904;
   localparam coef_type K1_GV = -19'sd46848;
   localparam coef_type K1_GU = -19'sd22528;
   localparam coef_type K1_BU = 19'sd116224;
   localparam term_type LUMA_OFS1 = 9'sd0;

   localparam term_type CHROMA_OFS = 9'sd128;

   localparam wide_type CLAMP_HI = 28'sh0FFFFFF;
   localparam wide_type CLAMP_LO = 28'sh000FFFF;

   typedef struct packed {
      mode_type mode;
      wide_type luma_a;
      wide_type luma_b;
      wide_type luma_c;
      wide_type luma_d;
      wide_type red_v;
      wide_type green_v;
      wide_type green_u;
      wide_type blue_u;
   } prod_type;

   typedef struct packed {
      mode_type mode;
      wide_type luma_a;
      wide_type luma_b;
      wide_type luma_c;
      wide_type luma_d;
      wide_type red_t;
      wide_type green_t;
      wide_type blue_t;
   } chroma_type;

   typedef struct packed {
      mode_type mode;
      wide_type red_a;
      wide_type green_a;
      wide_type blue_a;
      wide_type red_b;
      wide_type green_b;
      wide_type blue_b;
      wide_type red_c;
      wide_type green_c;
      wide_type blue_c;
      wide_type red_d;
      wide_type green_d;
      wide_type blue_d;
   } sum_type;

   typedef struct packed {
      byte_type red_a;
      byte_type green_a;
      byte_type blue_a;
      byte_type red_b;
      byte_type green_b;
      byte_type blue_b;
      byte_type red_c;
      byte_type green_c;
      byte_type blue_c;
      byte_type red_d;
      byte_type green_d;
      byte_type blue_d;
   } rgb_type;

   function automatic byte_type clamp_channel(input wide_type x);
      byte_type r;
      if (x > CLAMP_HI) begin
         r = 8'hFF;
      end else if (x <= CLAMP_LO) begin
         r = 8'h00;
      end else begin
         r = x[23:16];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/ytr_prod.sv
// First stage: luma and chroma products with mode-selected coefficients.
// Depends on ytr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ytr_prod import ytr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire mode_type mode,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire byte_type luma_a,
   input  wire byte_type luma_b,
   input  wire byte_type luma_c,
   input  wire byte_type luma_d,
   input  wire byte_type blue_diff,
   input  wire byte_type red_diff,
   output logic          out_valid,
   input  wire logic     out_stall,
   output prod_type      out_data
);

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;
   coef_type k_y, k_rv, k_gv, k_gu, k_bu;
   term_type ofs, u, v;

   function automatic wide_type mul(input coef_type k, input term_type t);
      return WIDE_W'(k) * WIDE_W'(t);
   endfunction

   function automatic term_type luma_term(input byte_type y, input term_type o);
      return $signed({1'b0, y}) - o;
   endfunction

   always_comb begin
      if (mode == MODE_PACKED_FULL) begin
         k_y = K1_Y; k_rv = K1_RV; k_gv = K1_GV; k_gu = K1_GU; k_bu = K1_BU;
         ofs = LUMA_OFS1;
      end else begin
         k_y = K0_Y; k_rv = K0_RV; k_gv = K0_GV; k_gu = K0_GU; k_bu = K0_BU;
         ofs = LUMA_OFS0;
      end
      u = $signed({1'b0, blue_diff}) - CHROMA_OFS;
      v = $signed({1'b0, red_diff}) - CHROMA_OFS;
      data_in.mode    = mode;
      data_in.luma_a  = mul(k_y, luma_term(luma_a, ofs));
      data_in.luma_b  = mul(k_y, luma_term(luma_b, ofs));
      data_in.luma_c  = mul(k_y, luma_term(luma_c, ofs));
      data_in.luma_d  = mul(k_y, luma_term(luma_d, ofs));
      data_in.red_v   = mul(k_rv, v);
      data_in.green_v = mul(k_gv, v);
      data_in.green_u = mul(k_gu, u);
      data_in.blue_u  = mul(k_bu, u);
   end

   assign in_stall  = valid_ff & out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### sv/ytr_mix.sv
// Second and third stages: combine chroma terms, then add them to each luma term.
// Depends on ytr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ytr_mix import ytr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire prod_type in_data,
   output logic          out_valid,
   input  wire logic     out_stall,
   output sum_type       out_data
);

   logic       chr_valid_ff, sum_valid_ff;
   logic       chr_stall;
   chroma_type chr_ff, chr_in;
   sum_type    sum_ff, sum_in;

   always_comb begin
      chr_in.mode    = in_data.mode;
      chr_in.luma_a  = in_data.luma_a;
      chr_in.luma_b  = in_data.luma_b;
      chr_in.luma_c  = in_data.luma_c;
      chr_in.luma_d  = in_data.luma_d;
      chr_in.red_t   = in_data.red_v;
      chr_in.green_t = in_data.green_v + in_data.green_u;
      chr_in.blue_t  = in_data.blue_u;
   end

   always_comb begin
      sum_in.mode    = chr_ff.mode;
      sum_in.red_a   = chr_ff.luma_a + chr_ff.red_t;
      sum_in.green_a = chr_ff.luma_a + chr_ff.green_t;
      sum_in.blue_a  = chr_ff.luma_a + chr_ff.blue_t;
      sum_in.red_b   = chr_ff.luma_b + chr_ff.red_t;
      sum_in.green_b = chr_ff.luma_b + chr_ff.green_t;
      sum_in.blue_b  = chr_ff.luma_b + chr_ff.blue_t;
      sum_in.red_c   = chr_ff.luma_c + chr_ff.red_t;
      sum_in.green_c = chr_ff.luma_c + chr_ff.green_t;
      sum_in.blue_c  = chr_ff.luma_c + chr_ff.blue_t;
      sum_in.red_d   = chr_ff.luma_d + chr_ff.red_t;
      sum_in.green_d = chr_ff.luma_d + chr_ff.green_t;
      sum_in.blue_d  = chr_ff.luma_d + chr_ff.blue_t;
   end

   assign chr_stall = sum_valid_ff & out_stall;
   assign in_stall  = chr_valid_ff & chr_stall;
   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chr_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (!in_stall) begin
            chr_valid_ff <= in_valid;
         end
         if (!chr_stall) begin
            sum_valid_ff <= chr_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         chr_ff <= chr_in;
      end
      if (!chr_stall && chr_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

### sv/ytr_clamp.sv
// Output stage: clamp each channel sum to a byte and blank the lower pair in 4:2:2 mode.
// Depends on ytr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ytr_clamp import ytr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire sum_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rgb_type      out_data
);

   logic    valid_ff;
   rgb_type data_ff, data_in;
   logic    keep_low;

   always_comb begin
      keep_low        = (in_data.mode == MODE_PLANAR_STUDIO);
      data_in.red_a   = clamp_channel(in_data.red_a);
      data_in.green_a = clamp_channel(in_data.green_a);
      data_in.blue_a  = clamp_channel(in_data.blue_a);
      data_in.red_b   = clamp_channel(in_data.red_b);
      data_in.green_b = clamp_channel(in_data.green_b);
      data_in.blue_b  = clamp_channel(in_data.blue_b);
      data_in.red_c   = keep_low ? clamp_channel(in_data.red_c)   : 8'h00;
      data_in.green_c = keep_low ? clamp_channel(in_data.green_c) : 8'h00;
      data_in.blue_c  = keep_low ? clamp_channel(in_data.blue_c)  : 8'h00;
      data_in.red_d   = keep_low ? clamp_channel(in_data.red_d)   : 8'h00;
      data_in.green_d = keep_low ? clamp_channel(in_data.green_d) : 8'h00;
      data_in.blue_d  = keep_low ? clamp_channel(in_data.blue_d)  : 8'h00;
   end

   assign in_stall  = valid_ff & out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### sv/yuv_to_rgb_pixel_group_core.sv
// YCbCr to RGB pixel-group core: mode register, product, mix and clamp stages.
// A request beat passes the product, chroma, sum and clamp registers, in that order, to rsp_valid.
// Throughput: one beat per cycle; four register stages, each held only by a stall behind it.
// Reset clears all stage valid bits and sets chroma_mode to 0; no clearing pass.
// Depends on ytr_pkg, ytr_prod, ytr_mix, ytr_clamp.
`timescale 1ns / 1ps
`default_nettype none

module yuv_to_rgb_pixel_group_core import ytr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire byte_type     req_luma_a,
   input  wire byte_type     req_luma_b,
   input  wire byte_type     req_luma_c,
   input  wire byte_type     req_luma_d,
   input  wire byte_type     req_blue_diff,
   input  wire byte_type     req_red_diff,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output byte_type          rsp_red_a,
   output byte_type          rsp_green_a,
   output byte_type          rsp_blue_a,
   output byte_type          rsp_red_b,
   output byte_type          rsp_green_b,
   output byte_type          rsp_blue_b,
   output byte_type          rsp_red_c,
   output byte_type          rsp_green_c,
   output byte_type          rsp_blue_c,
   output byte_type          rsp_red_d,
   output byte_type          rsp_green_d,
   output byte_type          rsp_blue_d,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire csr_addr_type csr_paddr,
   input  wire csr_data_type csr_pwdata,
   output csr_data_type      csr_prdata,
   output logic              csr_pready
);

   mode_type mode_ff;
   logic     csr_write;
   logic     sel_mode;
   logic     prod_valid, prod_stall;
   prod_type prod_data;
   logic     sum_valid, sum_stall;
   sum_type  sum_data;
   rgb_type  rgb;

   assign csr_pready = 1'b1;
   assign sel_mode   = (csr_paddr[2] == REG_CHROMA_MODE);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = sel_mode ? {{(CSR_DATA_W-1){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLANAR_STUDIO;
      end else if (csr_write && sel_mode) begin
         mode_ff <= mode_type'(csr_pwdata[0]);
      end
   end

   ytr_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .luma_a    (req_luma_a),
      .luma_b    (req_luma_b),
      .luma_c    (req_luma_c),
      .luma_d    (req_luma_d),
      .blue_diff (req_blue_diff),
      .red_diff  (req_red_diff),
      .out_valid (prod_valid),
      .out_stall (prod_stall),
      .out_data  (prod_data)
   );

   ytr_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_stall  (prod_stall),
      .in_data   (prod_data),
      .out_valid (sum_valid),
      .out_stall (sum_stall),
      .out_data  (sum_data)
   );

   ytr_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_stall  (sum_stall),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rgb)
   );

   assign rsp_red_a   = rgb.red_a;
   assign rsp_green_a = rgb.green_a;
   assign rsp_blue_a  = rgb.blue_a;
   assign rsp_red_b   = rgb.red_b;
   assign rsp_green_b = rgb.green_b;
   assign rsp_blue_b  = rgb.blue_b;
   assign rsp_red_c   = rgb.red_c;
   assign rsp_green_c = rgb.green_c;
   assign rsp_blue_c  = rgb.blue_c;
   assign rsp_red_d   = rgb.red_d;
   assign rsp_green_d = rgb.green_d;
   assign rsp_blue_d  = rgb.blue_d;

endmodule

`default_nettype wire

### sv/ytr_checker.sv
// Port-level checks for the YCbCr to RGB pixel-group core, bound to the top level.
// Depends on ytr_pkg and yuv_to_rgb_pixel_group_core.
`timescale 1ns / 1ps
`default_nettype none

module ytr_checker import ytr_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_stall,
   input wire logic     rsp_valid,
   input wire logic     rsp_stall,
   input wire byte_type rsp_red_a,
   input wire byte_type rsp_green_b,
   input wire byte_type rsp_blue_d
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_a)
         && $stable(rsp_green_b) && $stable(rsp_blue_d))
      else $error("stalled result beat changed");

   // drop all results on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // back-pressure only while a result waits at the output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // a freshly raised request stall follows a request beat taken into the first stage
   a_stall_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("request stall rose with no request beat taken");

endmodule

bind yuv_to_rgb_pixel_group_core ytr_checker u_checker (.*);

`default_nettype wire
